[rtl/wwr_pkg.sv]
// Package for the whole-word replace stream: character constants, config and
// command types, and the small character helper functions.
// Depends on nothing; every other file of the block uses it.
package wwr_pkg;

  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 4;
  localparam int HELD_DEPTH  = 8;
  localparam int HELD_IDX_W  = 3;
  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PTR_W   = 2;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int REG_IDX_W   = 3;
  localparam int REG_IDX_LSB = 3;

  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z   = 8'h7a;
  localparam logic [CHAR_W-1:0] FOLD_OFFSET = 8'd32;

  // Register indexes (byte address / 8)
  localparam logic [REG_IDX_W-1:0] REG_CASE_SENSITIVE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIND_LENGTH    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIND_CHARS     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REPLACE_LENGTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPLACE_CHARS  = 3'd4;

  typedef logic [HELD_DEPTH-1:0][CHAR_W-1:0] chars_t;

  typedef struct packed {
    logic              case_sensitive;
    logic [LEN_W-1:0]  find_length;
    chars_t            find_chars;
    logic [LEN_W-1:0]  replace_length;
    chars_t            replace_chars;
  } cfg_t;

  // One command: a leading segment (replacement or held characters), then
  // optionally the arriving character, then optionally a replacement.
  typedef struct packed {
    logic              x_repl;
    logic [LEN_W-1:0]  held_count;
    chars_t            held;
    logic              c_emit;
    logic [CHAR_W-1:0] ch;
    logic              y_repl;
    logic              last;
  } cmd_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z));
  endfunction

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ? c + FOLD_OFFSET : c;
  endfunction

  // Zero acts as one, anything above the cap saturates
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] cap);
    logic [LEN_W-1:0] r;
    r = len;
    if (len == '0) r = LEN_W'(1);
    else if (len > cap) r = cap;
    return r;
  endfunction

endpackage

[rtl/wwr_cfg.sv]
// Configuration registers of the whole-word replace stream behind an APB-style port.
// Depends on wwr_pkg.
module wwr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [wwr_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [wwr_pkg::DATA_W-1:0]  pwdata_i,
  output logic [wwr_pkg::DATA_W-1:0]  prdata_o,
  output wwr_pkg::cfg_t               cfg_o
);

  wwr_pkg::cfg_t                      cfg_q;
  logic [wwr_pkg::REG_IDX_W-1:0]      reg_idx;
  logic                               wr_en;

  assign reg_idx = paddr_i[wwr_pkg::REG_IDX_LSB +: wwr_pkg::REG_IDX_W];
  assign wr_en   = psel_i && penable_i && pwrite_i;

  // Write the addressed register in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.case_sensitive <= 1'b1;
      cfg_q.find_length    <= wwr_pkg::LEN_W'(1);
      cfg_q.find_chars     <= '0;
      cfg_q.replace_length <= wwr_pkg::LEN_W'(1);
      cfg_q.replace_chars  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        wwr_pkg::REG_CASE_SENSITIVE: cfg_q.case_sensitive <= pwdata_i[0];
        wwr_pkg::REG_FIND_LENGTH:    cfg_q.find_length    <= pwdata_i[wwr_pkg::LEN_W-1:0];
        wwr_pkg::REG_FIND_CHARS:     cfg_q.find_chars     <= pwdata_i;
        wwr_pkg::REG_REPLACE_LENGTH: cfg_q.replace_length <= pwdata_i[wwr_pkg::LEN_W-1:0];
        wwr_pkg::REG_REPLACE_CHARS:  cfg_q.replace_chars  <= pwdata_i;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      wwr_pkg::REG_CASE_SENSITIVE: prdata_o = wwr_pkg::DATA_W'(cfg_q.case_sensitive);
      wwr_pkg::REG_FIND_LENGTH:    prdata_o = wwr_pkg::DATA_W'(cfg_q.find_length);
      wwr_pkg::REG_FIND_CHARS:     prdata_o = cfg_q.find_chars;
      wwr_pkg::REG_REPLACE_LENGTH: prdata_o = wwr_pkg::DATA_W'(cfg_q.replace_length);
      wwr_pkg::REG_REPLACE_CHARS:  prdata_o = cfg_q.replace_chars;
      default:                     prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/wwr_front.sv]
// Front end: matches arriving characters against the search word, holds
// candidates and turns each word into an output command. Depends on wwr_pkg.
module wwr_front #(
  parameter int FIND_MAX = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wwr_pkg::cfg_t               cfg_i,
  input  logic                        accept_i,
  input  logic [wwr_pkg::CHAR_W-1:0]  in_char_i,
  input  logic                        in_last_i,
  output logic                        cmd_push_o,
  output wwr_pkg::cmd_t               cmd_o
);

  localparam int FindCapInt = (FIND_MAX < wwr_pkg::HELD_DEPTH) ? FIND_MAX : wwr_pkg::HELD_DEPTH;
  localparam logic [wwr_pkg::LEN_W-1:0] FindCap = wwr_pkg::LEN_W'(FindCapInt);

  logic                        at_word_start_q, at_word_start_d;
  logic [wwr_pkg::LEN_W-1:0]   match_count_q, match_count_d;
  wwr_pkg::chars_t             held_q;

  logic [wwr_pkg::LEN_W-1:0]   flen;
  logic [wwr_pkg::LEN_W-1:0]   m_after;
  logic [wwr_pkg::CHAR_W-1:0]  find_c;
  logic                        full_match;
  logic                        ends_word;
  logic                        same_char;
  logic                        hold;
  logic                        new_full;

  // Classify the arriving character
  always_comb begin
    flen       = wwr_pkg::clamp_len(cfg_i.find_length, FindCap);
    full_match = match_count_q >= flen;
    m_after    = full_match ? '0 : match_count_q;
    find_c     = cfg_i.find_chars[m_after[wwr_pkg::HELD_IDX_W-1:0]];
    if (cfg_i.case_sensitive) begin
      ends_word = in_char_i == wwr_pkg::CHAR_SPACE;
      same_char = in_char_i == find_c;
    end else begin
      ends_word = !wwr_pkg::is_letter(in_char_i);
      same_char = wwr_pkg::fold(in_char_i) == wwr_pkg::fold(find_c);
    end
    hold     = ((m_after != '0) || at_word_start_q) && (m_after < flen) && same_char;
    new_full = (m_after + wwr_pkg::LEN_W'(1)) >= flen;
  end

  // Build the command for this character
  always_comb begin
    cmd_o.x_repl     = full_match && ends_word;
    cmd_o.held_count = match_count_q;
    cmd_o.held       = held_q;
    cmd_o.ch         = in_char_i;
    cmd_o.last       = in_last_i;
    cmd_o.c_emit     = 1'b1;
    cmd_o.y_repl     = 1'b0;
    if (hold) begin
      if (!full_match) begin
        // held candidate at string end: replace or flush including this one
        cmd_o.x_repl = new_full;
        cmd_o.c_emit = in_last_i && !new_full;
      end else begin
        cmd_o.c_emit = in_last_i && !new_full;
        cmd_o.y_repl = in_last_i && new_full;
      end
    end
  end

  assign cmd_push_o = accept_i && (!hold || full_match || in_last_i);

  // Advance the match state
  always_comb begin
    match_count_d   = hold ? m_after + wwr_pkg::LEN_W'(1) : '0;
    at_word_start_d = in_char_i == wwr_pkg::CHAR_SPACE;
    if (in_last_i) begin
      match_count_d   = '0;
      at_word_start_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_word_start_q <= 1'b1;
      match_count_q   <= '0;
    end else if (accept_i) begin
      at_word_start_q <= at_word_start_d;
      match_count_q   <= match_count_d;
    end
  end

  // Store held candidates
  always_ff @(posedge clk_i) begin
    if (accept_i && hold) begin
      held_q[m_after[wwr_pkg::HELD_IDX_W-1:0]] <= in_char_i;
    end
  end

endmodule

[rtl/wwr_queue.sv]
// Command queue between front and back end of the whole-word replace stream.
// Depends on wwr_pkg.
module wwr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wwr_pkg::cmd_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output wwr_pkg::cmd_t  data_o,
  output logic           empty_o
);

  wwr_pkg::cmd_t                   mem_q [wwr_pkg::CMD_DEPTH];
  logic [wwr_pkg::CMD_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [wwr_pkg::CMD_PTR_W:0]     count_q;
  logic                            do_push, do_pop;

  assign full_o  = count_q == (wwr_pkg::CMD_PTR_W+1)'(wwr_pkg::CMD_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

[rtl/wwr_back.sv]
// Back end: walks each command one output word per cycle into the output
// register, while that register is free or being popped. Depends on wwr_pkg.
module wwr_back #(
  parameter int REPLACE_MAX = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wwr_pkg::cfg_t               cfg_i,
  input  wwr_pkg::cmd_t               cmd_i,
  input  logic                        cmd_empty_i,
  output logic                        cmd_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [wwr_pkg::CHAR_W-1:0]  out_char_o,
  output logic                        out_last_o
);

  localparam int RepCapInt =
    (REPLACE_MAX < wwr_pkg::HELD_DEPTH) ? REPLACE_MAX : wwr_pkg::HELD_DEPTH;
  localparam logic [wwr_pkg::LEN_W-1:0] RepCap = wwr_pkg::LEN_W'(RepCapInt);

  typedef enum logic [1:0] {
    SEG_X,
    SEG_C,
    SEG_Y
  } seg_e;

  seg_e                        seg_q, seg_d, cur_seg;
  logic [wwr_pkg::LEN_W-1:0]   idx_q, idx_d, pos, pos_nx;
  logic                        out_valid_q;
  logic [wwr_pkg::CHAR_W-1:0]  out_char_q, cur_char;
  logic                        out_last_q;
  logic [wwr_pkg::LEN_W-1:0]   rlen, xlen;
  logic                        step, done;

  assign rlen = wwr_pkg::clamp_len(cfg_i.replace_length, RepCap);
  assign xlen = cmd_i.x_repl ? rlen : cmd_i.held_count;
  assign step = !cmd_empty_i && (!out_valid_q || pop_i);

  // Pick the current segment, skipping empty ones
  always_comb begin
    if ((seg_q == SEG_X) && (idx_q < xlen)) begin
      cur_seg = SEG_X;
      pos     = idx_q;
    end else if ((seg_q != SEG_Y) && cmd_i.c_emit) begin
      cur_seg = SEG_C;
      pos     = '0;
    end else begin
      cur_seg = SEG_Y;
      pos     = (seg_q == SEG_Y) ? idx_q : '0;
    end
    pos_nx = pos + wwr_pkg::LEN_W'(1);
  end

  // Select the word and the next position
  always_comb begin
    seg_d = seg_q;
    idx_d = idx_q;
    done  = 1'b0;
    unique case (cur_seg)
      SEG_X: begin
        cur_char = cmd_i.x_repl ? cfg_i.replace_chars[pos[wwr_pkg::HELD_IDX_W-1:0]]
                                : cmd_i.held[pos[wwr_pkg::HELD_IDX_W-1:0]];
        if (pos_nx < xlen) begin
          seg_d = SEG_X;
          idx_d = pos_nx;
        end else if (cmd_i.c_emit) begin
          seg_d = SEG_C;
          idx_d = '0;
        end else if (cmd_i.y_repl) begin
          seg_d = SEG_Y;
          idx_d = '0;
        end else begin
          done = 1'b1;
        end
      end
      SEG_C: begin
        cur_char = cmd_i.ch;
        if (cmd_i.y_repl) begin
          seg_d = SEG_Y;
          idx_d = '0;
        end else begin
          done = 1'b1;
        end
      end
      default: begin
        cur_char = cfg_i.replace_chars[pos[wwr_pkg::HELD_IDX_W-1:0]];
        if (pos_nx < rlen) begin
          seg_d = SEG_Y;
          idx_d = pos_nx;
        end else begin
          done = 1'b1;
        end
      end
    endcase
    if (done) begin
      seg_d = SEG_X;
      idx_d = '0;
    end
  end

  assign cmd_pop_o = step && done;

  // Hold state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SEG_X;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        seg_q       <= seg_d;
        idx_q       <= idx_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_char_q <= cur_char;
      out_last_q <= cmd_i.last && done;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_char_o = out_char_q;
  assign out_last_o = out_last_q;

endmodule

[rtl/whole_word_replace_stream.sv]
// Top level of the whole-word replace stream: config port, front end,
// command queue and back end. Depends on wwr_pkg and the wwr_* modules.
//
// Characters enter through push/full and results leave through empty/pop, one
// word per cycle on each side unless held by full or empty. A character that
// may start or continue a match is held in the front end and yields nothing
// until its word is decided. Every other accepted character, and every string
// end, turns into one command in a four-entry queue. The back end emits a
// command word by word: one for a plain character, up to nine for a decided
// word followed by the character that closed it, and up to sixteen when a
// replacement is followed by a second one at string end (possible only with a
// space in the search word). Input is refused only while the queue holds four
// commands, so the stream runs at one character per cycle while the output
// keeps pace, and the queue absorbs the bursts from flushes and replacements.
// The first output word of a command passes the queue and the output register.
// Configuration is written through the APB-style port with 64-bit registers
// at byte addresses 0, 8, 16, 24, 32; the user must write it only while the
// stream is idle, and the block itself does not enforce this.
module whole_word_replace_stream #(
  parameter int FIND_MAX    = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [wwr_pkg::CHAR_W-1:0]  in_char_i,
  input  logic                        in_last_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [wwr_pkg::CHAR_W-1:0]  out_char_o,
  output logic                        out_last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wwr_pkg::ADDR_W-1:0]  paddr,
  input  logic [wwr_pkg::DATA_W-1:0]  pwdata,
  output logic [wwr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  wwr_pkg::cfg_t  cfg;
  wwr_pkg::cmd_t  cmd_in, cmd_out;
  logic           accept, cmd_push, cmd_pop, cmd_empty;

  assign pready = 1'b1;
  assign accept = push && !full;

  wwr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  wwr_front #(
    .FIND_MAX (FIND_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (accept),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  wwr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  wwr_back #(
    .REPLACE_MAX (REPLACE_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o)
  );

endmodule
